[rtl/mhpq_pkg.sv]
// Shared types and codes for the min-heap priority queue.
// Holds the item and result structs, the opcode and status codes and the default capacity.
// No dependencies.
`default_nettype none

package mhpq_pkg;

  localparam int unsigned DEF_CAPACITY = 128;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [7:0]         entry_total;
    logic               is_empty;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/min_heap_priority_queue_unit.sv]
// Clear, a refused operation and an unused opcode strobe their result in the cycle after they
// are accepted. An insert passes S_UP_CHK and S_UP_CMP per level climbed, until the root or a
// compare stops it. An extract reads the root, then the last entry, then per level passes
// S_DN_CHK, S_DN_L, S_DN_R (skipped at a node with only a left child) and S_DN_CMP, until a
// leaf or a compare stops it. Throughput: one item at a time, paced by the single read port;
// busy is low in the strobe cycle. The receiver cannot stall. Synchronous reset empties the heap.
`default_nettype none

module min_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IW    = AW + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_CHK  = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_EX_ROOT = 4'd3;
  localparam logic [3:0] S_EX_LAST = 4'd4;
  localparam logic [3:0] S_DN_CHK  = 4'd5;
  localparam logic [3:0] S_DN_L    = 4'd6;
  localparam logic [3:0] S_DN_R    = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      cidx_r, cidx_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] cand_r, cand_nxt;
  logic signed [31:0] removed_r, removed_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic signed [31:0] heap_mem [CAPACITY];
  logic signed [31:0] rdata_r;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  logic signed [31:0] cmp_a, cmp_b;
  logic               cmp_lt;

  logic [IW-1:0]      left_w, right_w, n_w;
  logic [AW-1:0]      parent;
  logic               accept;
  logic               finish;
  logic [1:0]         status_nxt;

  assign accept  = start && (state_r == S_IDLE);
  assign left_w  = {1'b0, pos_r, 1'b1};
  assign right_w = left_w + IW'(1);
  assign n_w     = IW'(count_r);
  assign parent  = AW'((pos_r - AW'(1)) >> 1);

  // The single shared comparator; its operands follow the sequencer step.
  always_comb begin
    case (state_r)
      S_UP_CMP: begin
        cmp_a = val_r;
        cmp_b = rdata_r;
      end
      S_DN_R: begin
        cmp_a = rdata_r;
        cmp_b = cand_r;
      end
      default: begin
        cmp_a = cand_r;
        cmp_b = val_r;
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  // Heap storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rdata_r <= heap_mem[raddr];
  end

  // Sift steps carry the moving value in val_r and shift entries into the hole, which leaves
  // the same contents as a chain of swaps.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    cidx_nxt    = cidx_r;
    val_nxt     = val_r;
    cand_nxt    = cand_r;
    removed_nxt = removed_r;
    raddr       = '0;
    we          = 1'b0;
    waddr       = pos_r;
    wdata       = val_r;
    finish      = 1'b0;
    status_nxt  = ST_OK;

    case (state_r)
      S_IDLE: begin
        removed_nxt = '0;
        if (accept) begin
          case (in_item.opcode)
            OP_INSERT: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
                finish     = 1'b1;
              end else begin
                pos_nxt   = count_r[AW-1:0];
                val_nxt   = in_item.value;
                count_nxt = count_r + CNT_W'(1);
                state_nxt = S_UP_CHK;
              end
            end
            OP_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                finish     = 1'b1;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_EX_ROOT;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              finish    = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_UP_CHK: begin
        if (pos_r == '0) begin
          we     = 1'b1;
          finish = 1'b1;
        end else begin
          raddr     = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cmp_lt) begin
          wdata     = rdata_r;
          pos_nxt   = parent;
          state_nxt = S_UP_CHK;
        end else begin
          finish = 1'b1;
        end
      end
      S_EX_ROOT: begin
        removed_nxt = rdata_r;
        raddr       = count_r[AW-1:0];
        state_nxt   = S_EX_LAST;
      end
      S_EX_LAST: begin
        val_nxt   = rdata_r;
        pos_nxt   = '0;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_w >= n_w) begin
          we     = 1'b1;
          finish = 1'b1;
        end else begin
          raddr     = left_w[AW-1:0];
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        cand_nxt = rdata_r;
        cidx_nxt = left_w[AW-1:0];
        if (right_w < n_w) begin
          raddr     = right_w[AW-1:0];
          state_nxt = S_DN_R;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_R: begin
        // The left child wins a tie.
        if (cmp_lt) begin
          cand_nxt = rdata_r;
          cidx_nxt = right_w[AW-1:0];
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (cmp_lt) begin
          wdata     = cand_r;
          pos_nxt   = cidx_r;
          state_nxt = S_DN_CHK;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = S_IDLE;
    end

    out_valid_nxt              = finish;
    out_item_nxt.status        = status_nxt;
    out_item_nxt.removed_value = removed_nxt;
    out_item_nxt.entry_total   = 8'(count_nxt);
    out_item_nxt.is_empty      = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cidx_r     <= cidx_nxt;
    val_r      <= val_nxt;
    cand_r     <= cand_nxt;
    removed_r  <= removed_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while a sift is still running");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.opcode == OP_CLEAR) |=> (out_valid_r && count_r == '0))
    else $error("clear did not empty the heap in one cycle");

  a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_CMP) |-> (IW'(cidx_r) < n_w))
    else $error("sift-down child index beyond the entry count");
`endif

endmodule

`default_nettype wire
